/* design/uol_pkg.sv */
`timescale 1ns / 1ps
package uol_pkg;
    localparam int unsigned CAPACITY_DEF   = 16;
    localparam int unsigned DATA_WIDTH_DEF = 32;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned VALUE_W  = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_PUSH    = 3'd2,
        CMD_REMVAL  = 3'd3,
        CMD_REMPOS  = 3'd4,
        CMD_POP     = 3'd5,
        CMD_READ    = 3'd6,
        CMD_HAS     = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_BADPOS  = 3'd2,
        ST_FULL    = 3'd3,
        ST_MISSING = 3'd4
    } status_t;

    // datapath -> controller, cycle after the compare
    typedef struct packed {
        logic hit;
    } dp_status_t;
endpackage

/* design/unique_ordered_list.sv */
`timescale 1ns / 1ps
// unique_ordered_list: ordered list of distinct values, CAPACITY entries.
//
// Command channel: present command/value/position with start high; the
// item is taken on the edge where start is high and busy is low.
// Result channel: done pulses for one cycle with status, data_out, count
// and full_res. The receiver cannot stall; every item gives one result.
//
// Timing: on acceptance every cell compares the broadcast value into a
// registered hit vector; in the EXEC state the controller decides and the
// row of cells shifts in one step. done is high in the cycle after that;
// busy is high for one cycle, in EXEC, so no new item is taken until the
// last one has been decided.
//
// Reset (rst_n, async, low) clears the count and the controller. Cells
// are not cleared: only entries below the count are ever read.
// data_out is zero for every command that fails or returns nothing.
module unique_ordered_list #(
    parameter int unsigned CAPACITY   = uol_pkg::CAPACITY_DEF,
    parameter int unsigned DATA_WIDTH = uol_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [uol_pkg::CMD_W-1:0]    command,
    input  logic [uol_pkg::VALUE_W-1:0]  value,
    input  logic [uol_pkg::POS_W-1:0]    position,
    output logic                         done,
    output logic [uol_pkg::STATUS_W-1:0] status,
    output logic [uol_pkg::VALUE_W-1:0]  data_out,
    output logic [uol_pkg::POS_W-1:0]    count,
    output logic                         full_res
);
    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    uol_pkg::dp_status_t   stat;
    logic                  load;
    logic [CNT_W-1:0]      cnt;
    logic                  do_ins;
    logic                  do_rem;
    logic [IDX_W-1:0]      op_pos;
    logic                  pos_from_hit;
    logic [IDX_W-1:0]      rd_pos;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DATA_WIDTH-1:0] val_q;
    logic [DATA_WIDTH-1:0] value_in;

    // value taken modulo 2^DATA_WIDTH
    assign value_in = DATA_WIDTH'(value);

    uol_ctrl #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .position(position), .stat(stat), .rd_data(rd_data), .val_q(val_q),
        .busy(busy), .load(load), .count_q(cnt), .do_ins(do_ins),
        .do_rem(do_rem), .op_pos(op_pos), .pos_from_hit(pos_from_hit),
        .rd_pos(rd_pos), .done(done), .status(status), .data_out(data_out),
        .count(count), .full_res(full_res)
    );

    uol_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .load(load), .value(value_in), .count(cnt),
        .do_ins(do_ins), .do_rem(do_rem), .op_pos(op_pos),
        .pos_from_hit(pos_from_hit), .rd_pos(rd_pos), .stat(stat),
        .rd_data(rd_data), .val_q(val_q)
    );
endmodule

/* design/uol_datapath.sv */
`timescale 1ns / 1ps
// Row of cells: compare broadcast value, then shift / write in one step.
module uol_datapath #(
    parameter int unsigned CAPACITY   = uol_pkg::CAPACITY_DEF,
    parameter int unsigned DATA_WIDTH = uol_pkg::DATA_WIDTH_DEF,
    parameter int unsigned IDX_W      = $clog2(CAPACITY),
    parameter int unsigned CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [CNT_W-1:0]      count,
    input  logic                  do_ins,
    input  logic                  do_rem,
    input  logic [IDX_W-1:0]      op_pos,
    input  logic                  pos_from_hit,
    input  logic [IDX_W-1:0]      rd_pos,
    output uol_pkg::dp_status_t   stat,
    output logic [DATA_WIDTH-1:0] rd_data,
    output logic [DATA_WIDTH-1:0] val_q
);
    logic [DATA_WIDTH-1:0] cell_reg [CAPACITY];
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CAPACITY-1:0]   match_reg, match_next;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      eff_pos;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_next[i] = (cell_reg[i] == value) && (CNT_W'(i) < count);
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_reg[i])
                hit_idx = IDX_W'(i);
        end
    end

    assign eff_pos    = pos_from_hit ? hit_idx : op_pos;
    assign stat.hit   = |match_reg;
    assign rd_data    = cell_reg[rd_pos];
    assign val_q      = val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= '0;
        else if (load)
            match_reg <= match_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            val_reg <= value;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (do_ins)
            begin
                if (IDX_W'(i) == eff_pos)
                    cell_reg[i] <= val_reg;
                else if (IDX_W'(i) > eff_pos && i > 0)
                    cell_reg[i] <= cell_reg[(i > 0) ? i - 1 : 0];
            end
            else if (do_rem)
            begin
                if (IDX_W'(i) >= eff_pos && i < CAPACITY - 1)
                    cell_reg[i] <= cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end
endmodule

/* design/uol_ctrl.sv */
`timescale 1ns / 1ps
// Two-state sequencer: compare, then decide / update / report.
module uol_ctrl #(
    parameter int unsigned CAPACITY   = uol_pkg::CAPACITY_DEF,
    parameter int unsigned DATA_WIDTH = uol_pkg::DATA_WIDTH_DEF,
    parameter int unsigned IDX_W      = $clog2(CAPACITY),
    parameter int unsigned CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [uol_pkg::CMD_W-1:0]   command,
    input  logic [uol_pkg::POS_W-1:0]   position,
    input  uol_pkg::dp_status_t         stat,
    input  logic [DATA_WIDTH-1:0]       rd_data,
    input  logic [DATA_WIDTH-1:0]       val_q,
    output logic                        busy,
    output logic                        load,
    output logic [CNT_W-1:0]            count_q,
    output logic                        do_ins,
    output logic                        do_rem,
    output logic [IDX_W-1:0]            op_pos,
    output logic                        pos_from_hit,
    output logic [IDX_W-1:0]            rd_pos,
    output logic                        done,
    output logic [uol_pkg::STATUS_W-1:0] status,
    output logic [uol_pkg::VALUE_W-1:0] data_out,
    output logic [uol_pkg::POS_W-1:0]   count,
    output logic                        full_res
);
    typedef enum logic [1:0] { S_IDLE = 2'b01, S_EXEC = 2'b10 } state_t;

    state_t                         state_reg, state_next;
    uol_pkg::cmd_t                  cmd_reg;
    logic [uol_pkg::POS_W-1:0]      pos_reg;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           done_reg;
    logic [uol_pkg::STATUS_W-1:0]   st_reg, st_next;
    logic [uol_pkg::VALUE_W-1:0]    dat_reg, dat_next;
    logic [uol_pkg::POS_W-1:0]      pos_ext_cnt;
    logic                           exec;
    logic                           is_full;
    logic                           empty;
    logic                           pos_lt;
    logic                           pos_le;

    assign exec     = (state_reg == S_EXEC);
    assign busy     = exec;
    assign load     = start && !busy;
    assign count_q  = cnt_reg;
    assign is_full  = (cnt_reg == CNT_W'(CAPACITY));
    assign empty    = (cnt_reg == '0);
    assign pos_lt   = (32'(pos_reg) < 32'(cnt_reg));
    assign pos_le   = (32'(pos_reg) <= 32'(cnt_reg));
    assign pos_ext_cnt = uol_pkg::POS_W'(cnt_reg);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        st_next      = uol_pkg::ST_OK;
        dat_next     = '0;
        do_ins       = 1'b0;
        do_rem       = 1'b0;
        op_pos       = pos_reg[IDX_W-1:0];
        pos_from_hit = 1'b0;
        rd_pos       = pos_reg[IDX_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (load)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (cmd_reg)
                    uol_pkg::CMD_APPEND, uol_pkg::CMD_INSERT, uol_pkg::CMD_PUSH:
                    begin
                        if (cmd_reg == uol_pkg::CMD_APPEND)
                            op_pos = IDX_W'(cnt_reg);
                        else if (cmd_reg == uol_pkg::CMD_PUSH)
                            op_pos = '0;
                        if (cmd_reg == uol_pkg::CMD_INSERT && !pos_le)
                            st_next = uol_pkg::ST_BADPOS;
                        else if (stat.hit)
                            st_next = uol_pkg::ST_DUP;
                        else if (is_full)
                            st_next = uol_pkg::ST_FULL;
                        else
                        begin
                            do_ins   = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    uol_pkg::CMD_REMVAL:
                    begin
                        pos_from_hit = 1'b1;
                        if (stat.hit)
                        begin
                            do_rem   = 1'b1;
                            cnt_next = cnt_reg - 1'b1;
                            dat_next = uol_pkg::VALUE_W'(val_q);
                        end
                        else
                            st_next = uol_pkg::ST_MISSING;
                    end
                    uol_pkg::CMD_REMPOS, uol_pkg::CMD_POP:
                    begin
                        if (cmd_reg == uol_pkg::CMD_POP)
                        begin
                            op_pos = IDX_W'(cnt_reg - 1'b1);
                            rd_pos = IDX_W'(cnt_reg - 1'b1);
                        end
                        if (empty)
                            st_next = uol_pkg::ST_MISSING;
                        else if (cmd_reg == uol_pkg::CMD_REMPOS && !pos_lt)
                            st_next = uol_pkg::ST_BADPOS;
                        else
                        begin
                            do_rem   = 1'b1;
                            cnt_next = cnt_reg - 1'b1;
                            dat_next = uol_pkg::VALUE_W'(rd_data);
                        end
                    end
                    uol_pkg::CMD_READ:
                    begin
                        if (!pos_lt)
                            st_next = uol_pkg::ST_BADPOS;
                        else
                            dat_next = uol_pkg::VALUE_W'(rd_data);
                    end
                    uol_pkg::CMD_HAS:
                    begin
                        if (!stat.hit)
                            st_next = uol_pkg::ST_MISSING;
                    end
                    default: ;
                endcase
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= uol_pkg::cmd_t'(command);
            pos_reg <= position;
        end
        if (exec)
        begin
            st_reg  <= st_next;
            dat_reg <= dat_next;
        end
    end

    assign done     = done_reg;
    assign status   = st_reg;
    assign data_out = dat_reg;
    assign count    = uol_pkg::POS_W'(cnt_reg);
    assign full_res = (cnt_reg == CNT_W'(CAPACITY));

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY)) else $error("count above capacity");
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(do_ins && do_rem)) else $error("insert and remove together");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> done_reg) else $error("result missing");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> $stable(cnt_reg)) else $error("count moved while idle");
    a_count_port: assert property (@(posedge clk) disable iff (!rst_n)
        pos_ext_cnt == count) else $error("count port mismatch");
endmodule

/* verif/tb_unique_ordered_list.sv */
`timescale 1ns / 1ps
// Self-checking bench for the ordered distinct-value list.
module tb_unique_ordered_list;
    localparam int unsigned CAP        = uol_pkg::CAPACITY_DEF;
    localparam int unsigned POS_W      = uol_pkg::POS_W;
    localparam int unsigned RAND_ITEMS = 590;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // expected result of one item
    typedef struct {
        uol_pkg::status_t st;
        logic [31:0]      data;
        logic [POS_W-1:0] cnt;
        logic             full;
    } list_result_t;

    // list predictor plus queue of pending results
    class list_scoreboard;
        logic [31:0]  vals[CAP];
        int unsigned  n;
        list_result_t pending[$];
        int unsigned  errors;

        function int find(logic [31:0] v);
            for (int i = 0; i < n; i++)
                if (vals[i] == v) return i;
            return -1;
        endfunction

        function uol_pkg::status_t place(logic [31:0] v, int unsigned p);
            if (p > n) return uol_pkg::ST_BADPOS;
            if (find(v) >= 0) return uol_pkg::ST_DUP;
            if (n >= CAP) return uol_pkg::ST_FULL;
            for (int i = n; i > p; i--) vals[i] = vals[i-1];
            vals[p] = v;
            n++;
            return uol_pkg::ST_OK;
        endfunction

        function logic [31:0] take(int unsigned p);
            logic [31:0] v;
            v = vals[p];
            for (int i = p; i + 1 < n; i++) vals[i] = vals[i+1];
            n--;
            return v;
        endfunction

        // an accepted input item: compute its result
        function void note_item(uol_pkg::cmd_t c, logic [31:0] v, logic [POS_W-1:0] p);
            list_result_t r;
            int hit;
            r.st = uol_pkg::ST_OK;
            r.data = '0;
            case (c)
                uol_pkg::CMD_APPEND: r.st = place(v, n);
                uol_pkg::CMD_INSERT: r.st = place(v, p);
                uol_pkg::CMD_PUSH:   r.st = place(v, 0);
                uol_pkg::CMD_REMVAL:
                begin
                    hit = find(v);
                    if (hit >= 0) r.data = take(hit);
                    else r.st = uol_pkg::ST_MISSING;
                end
                uol_pkg::CMD_REMPOS:
                begin
                    if (n == 0) r.st = uol_pkg::ST_MISSING;
                    else if (p >= n) r.st = uol_pkg::ST_BADPOS;
                    else r.data = take(p);
                end
                uol_pkg::CMD_POP:
                begin
                    if (n == 0) r.st = uol_pkg::ST_MISSING;
                    else r.data = take(n - 1);
                end
                uol_pkg::CMD_READ:
                begin
                    if (p >= n) r.st = uol_pkg::ST_BADPOS;
                    else r.data = vals[p];
                end
                default:
                begin
                    if (find(v) < 0) r.st = uol_pkg::ST_MISSING;
                end
            endcase
            r.cnt = POS_W'(n);
            r.full = (n == CAP);
            pending.push_back(r);
        endfunction

        function void check_result(logic [2:0] st, logic [31:0] d,
                                   logic [POS_W-1:0] c, logic f);
            list_result_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.st)
            begin
                $error("status: expected %0d actual %0d", e.st, st);
                errors++;
            end
            if (d !== e.data)
            begin
                $error("data_out: expected %h actual %h", e.data, d);
                errors++;
            end
            if (c !== e.cnt)
            begin
                $error("count: expected %0d actual %0d", e.cnt, c);
                errors++;
            end
            if (f !== e.full)
            begin
                $error("full_res: expected %0d actual %0d", e.full, f);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [uol_pkg::CMD_W-1:0] command = '0;
    logic [uol_pkg::VALUE_W-1:0] value = '0;
    logic [POS_W-1:0] position = '0;
    logic done;
    logic [uol_pkg::STATUS_W-1:0] status;
    logic [uol_pkg::VALUE_W-1:0] data_out;
    logic [POS_W-1:0] count;
    logic full_res;

    list_scoreboard sb = new();
    int unsigned cycles = 0;
    bit gaps_on = 1'b1;
    // small pool of values so duplicates and hits are common
    logic [31:0] pool[8];

    unique_ordered_list dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .value(value), .position(position),
        .done(done), .status(status), .data_out(data_out),
        .count(count), .full_res(full_res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // results cannot be held off: check every strobe
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
            sb.check_result(status, data_out, count, full_res);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // present one item, hold start until taken; optional idle burst first
    task automatic send_item(uol_pkg::cmd_t c, logic [31:0] v, logic [POS_W-1:0] p);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        command <= c;
        value <= v;
        position <= p;
        // accepted at an edge with start high and busy low
        do @(posedge clk); while (busy);
        sb.note_item(c, v, p);
    endtask

    task automatic send_random;
        uol_pkg::cmd_t c;
        logic [31:0] v;
        int k;
        k = $urandom_range(0, 15);
        // bias towards inserts while short, removals while long
        if (k < 6)
            c = uol_pkg::cmd_t'(3'((sb.n > 12) ? $urandom_range(3, 5)
                                               : $urandom_range(0, 2)));
        else
            c = uol_pkg::cmd_t'(3'($urandom_range(0, 7)));
        v = ($urandom_range(0, 3) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
        send_item(c, v, POS_W'($urandom_range(0, sb.n + 1 > 31 ? 31 : sb.n + 1)));
        if ($urandom_range(0, 19) == 0)
            send_item(uol_pkg::cmd_t'(3'($urandom_range(0, 7))), $urandom(),
                      POS_W'($urandom_range(0, 31)));
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++) pool[i] = $urandom();
        pool[0] = '0;
        pool[1] = '1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-store cases, fill to full, overflow, removals
        send_item(uol_pkg::CMD_POP, '0, '0);
        send_item(uol_pkg::CMD_REMPOS, '0, '0);
        send_item(uol_pkg::CMD_READ, '0, '0);
        send_item(uol_pkg::CMD_REMVAL, 32'h1, '0);
        send_item(uol_pkg::CMD_INSERT, 32'h5, 5'd1);    // position past count
        send_item(uol_pkg::CMD_APPEND, '0, '0);
        send_item(uol_pkg::CMD_APPEND, '0, '0);         // duplicate
        send_item(uol_pkg::CMD_PUSH, '1, '0);
        send_item(uol_pkg::CMD_INSERT, 32'hA5A5_5A5A, 5'd1);
        send_item(uol_pkg::CMD_HAS, '1, '0);
        send_item(uol_pkg::CMD_HAS, 32'h1234, '0);
        for (int i = 0; i < 13; i++)
            send_item(uol_pkg::CMD_APPEND, 32'h100 + i, '0);
        send_item(uol_pkg::CMD_APPEND, 32'h999, '0);    // full
        send_item(uol_pkg::CMD_INSERT, '0, 5'd31);      // bad position wins over dup/full
        send_item(uol_pkg::CMD_INSERT, '0, 5'd3);       // duplicate wins over full
        send_item(uol_pkg::CMD_READ, '0, 5'd15);
        send_item(uol_pkg::CMD_READ, '0, 5'd16);
        send_item(uol_pkg::CMD_REMPOS, '0, 5'd16);
        send_item(uol_pkg::CMD_REMPOS, '0, 5'd0);
        send_item(uol_pkg::CMD_REMVAL, 32'h105, '0);
        send_item(uol_pkg::CMD_POP, '0, '0);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i > RAND_ITEMS - 80) gaps_on = 1'b0;
            send_random();
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* files.f */
design/uol_pkg.sv
design/uol_datapath.sv
design/uol_ctrl.sv
design/unique_ordered_list.sv
verif/tb_unique_ordered_list.sv
